FILE: rtl/untp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// untp_pkg
// Shared types and constants for the unsigned number token parser: the parse
// phase codes, the parser state record, the result record and the character
// codes that the parser recognises.
// ----------------------------------------------------------------------------
package untp_pkg;

    // Position saturates at this count of characters.
    localparam int MAX_LEN = 255;
    localparam int POS_W   = $clog2(MAX_LEN + 1);

    // Character codes.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    // Digit value that marks a byte which is not a hex digit.
    localparam logic [4:0] NOT_HEX = 5'd16;
    localparam logic [4:0] DEC_BASE = 5'd10;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_ZERO   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_REST   = 3'd4,
        PH_FAIL   = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic               hex_mode;
        logic [31:0]        accum;
        logic               digit_seen;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   rest_start;
    } state_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] value;
        logic [7:0]  rest_offset;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_LEAD,
        hex_mode:   1'b0,
        accum:      32'd0,
        digit_seen: 1'b0,
        position:   '0,
        rest_start: '0
    };

endpackage
`default_nettype wire

FILE: rtl/untp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// untp_step
// Combinational parse step: takes the current parser state and one
// character, and gives the next state and the result that a final
// character produces.
// ----------------------------------------------------------------------------
module untp_step (
    input  var untp_pkg::state_t  state_cur,
    input  wire logic [7:0]       ch,
    input  wire logic             last,
    output untp_pkg::state_t      state_next,
    output untp_pkg::result_t     result
);
    import untp_pkg::*;

    // Hex digit value of a byte, or NOT_HEX.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = c - CH_ZERO;
                hex_value = d[4:0];
            end
            else if (c >= CH_UP_A && c <= CH_UP_F)
            begin
                d = c - CH_UP_A + 8'd10;
                hex_value = d[4:0];
            end
            else if (c >= CH_LOW_A && c <= CH_LOW_F)
            begin
                d = c - CH_LOW_A + 8'd10;
                hex_value = d[4:0];
            end
            else
            begin
                hex_value = NOT_HEX;
            end
        end
    endfunction

    // Digit phase: add a digit or end the token.
    function automatic state_t digit_char(input state_t s, input logic [7:0] c);
        state_t      r;
        logic [4:0]  d;
        logic [31:0] scaled;
        begin
            r = s;
            d = hex_value(c);
            scaled = 32'd0;
            if (d != NOT_HEX)
            begin
                if (!s.hex_mode && d >= DEC_BASE)
                begin
                    r.phase = PH_FAIL;
                end
                else
                begin
                    // Multiply by 16 or by 10 as shift and add, wrapping.
                    if (s.hex_mode)
                        scaled = {s.accum[27:0], 4'b0000};
                    else
                        scaled = {s.accum[28:0], 3'b000} + {s.accum[30:0], 1'b0};
                    r.accum = scaled + {27'd0, d};
                    r.digit_seen = 1'b1;
                end
            end
            else if (!s.digit_seen || c != CH_SPACE)
            begin
                r.phase = PH_FAIL;
            end
            else
            begin
                r.phase = PH_TRAIL;
            end
            digit_char = r;
        end
    endfunction

    state_t                  stepped;
    state_t                  zero_seed;
    logic [POS_W+7:0]        off_wide;

    // Phase transition for one character.
    always_comb
    begin
        stepped = state_cur;
        zero_seed = state_cur;
        zero_seed.accum = 32'd0;
        zero_seed.digit_seen = 1'b1;
        zero_seed.phase = PH_DIGITS;
        unique case (state_cur.phase)
            PH_LEAD:
            begin
                if (ch == CH_SPACE)
                begin
                    stepped = state_cur;
                end
                else if (ch == CH_DOLLAR)
                begin
                    stepped.hex_mode = 1'b1;
                    stepped.phase = PH_DIGITS;
                end
                else if (ch == CH_ZERO)
                begin
                    stepped.phase = PH_ZERO;
                end
                else
                begin
                    stepped.phase = PH_DIGITS;
                    stepped = digit_char(stepped, ch);
                end
            end
            PH_ZERO:
            begin
                if (ch == CH_LOW_X || ch == CH_UP_X)
                begin
                    stepped.hex_mode = 1'b1;
                    stepped.phase = PH_DIGITS;
                end
                else
                begin
                    stepped = digit_char(zero_seed, ch);
                end
            end
            PH_DIGITS:
            begin
                stepped = digit_char(state_cur, ch);
            end
            PH_TRAIL:
            begin
                if (ch != CH_SPACE)
                begin
                    stepped.rest_start = state_cur.position;
                    stepped.phase = PH_REST;
                end
            end
            PH_REST:
            begin
                stepped = state_cur;
            end
            default:
            begin
                stepped.phase = PH_FAIL;
            end
        endcase

        // Count of characters consumed, saturating.
        if (state_cur.position < POS_W'(MAX_LEN))
            stepped.position = state_cur.position + POS_W'(1);
    end

    // Result of a string that ends with this character.
    always_comb
    begin
        result.ok = 1'b0;
        result.value = 32'd0;
        off_wide = '0;
        priority if (stepped.phase == PH_ZERO)
        begin
            result.ok = 1'b1;
            off_wide = {8'd0, stepped.position};
        end
        else if (stepped.phase == PH_DIGITS && stepped.digit_seen)
        begin
            result.ok = 1'b1;
            result.value = stepped.accum;
            off_wide = {8'd0, stepped.position};
        end
        else if (stepped.phase == PH_TRAIL)
        begin
            result.ok = 1'b1;
            result.value = stepped.accum;
            off_wide = {8'd0, stepped.position};
        end
        else if (stepped.phase == PH_REST)
        begin
            result.ok = 1'b1;
            result.value = stepped.accum;
            off_wide = {8'd0, stepped.rest_start};
        end
        else
        begin
            result.ok = 1'b0;
        end
        result.rest_offset = off_wide[7:0];
    end

    // A final character returns the parser to its reset state.
    assign state_next = last ? STATE_RESET : stepped;

endmodule
`default_nettype wire

FILE: rtl/unsigned_number_token_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_number_token_parser_core
// Parses an unsigned 32-bit decimal or hex number token from a string that
// arrives one character per item, and gives one result per string.
// ----------------------------------------------------------------------------
//  Channel | Signals                          | Item
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, ch, last     | one character of the string
//  out     | out_valid, out_ready, ok, value, | one parse result, on the final
//          | rest_offset                      | character of each string
//
// One character is taken every cycle unless a final one waits for the
// result slot; the parse step is one combinational pass between the input
// register and the parser state / result registers that hold its outcome.
// Reset returns the parser to the leading-space phase and empties both
// registers. A stalled result only holds back a later final character;
// other characters keep flowing past it.
// ----------------------------------------------------------------------------
module unsigned_number_token_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             ok,
    output logic [31:0]      value,
    output logic [7:0]       rest_offset
);
    import untp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  ch_reg;
    logic        last_reg;
    state_t      state_reg;
    state_t      state_next;
    result_t     step_result;
    logic        out_valid_reg;
    logic        ok_reg;
    logic [31:0] value_reg;
    logic [7:0]  rest_offset_reg;
    logic        advance;

    // The held item moves on unless it is final and a full result slot stalls.
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    untp_step u_step (
        .state_cur  (state_reg),
        .ch         (ch_reg),
        .last       (last_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            ok_reg          <= step_result.ok;
            value_reg       <= step_result.value;
            rest_offset_reg <= step_result.rest_offset;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign value       = value_reg;
    assign rest_offset = rest_offset_reg;

    // A failed parse reports zero value and zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |-> value_reg == 32'd0 && rest_offset_reg == 8'd0)
        else $error("failed parse with non-zero payload");

    // A final character restarts the parser from reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> state_reg == STATE_RESET)
        else $error("parser state not cleared after final character");

    // A final character always fills the result slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> out_valid_reg)
        else $error("final character produced no result");

    // Trailing and rest phases are only reached after a digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_TRAIL || state_reg.phase == PH_REST |-> state_reg.digit_seen)
        else $error("token ended without a digit");

endmodule
`default_nettype wire

FILE: test/unsigned_number_token_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_number_token_parser_core_tb
// Feeds argument strings one character per item into the number token parser
// and checks every parse result against a predictor kept in the testbench.
// The strings are a directed set of corner cases followed by random tokens,
// noise and broken tokens, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module unsigned_number_token_parser_core_tb;

    import untp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam logic [4:0] HEX_BASE = 5'd16;
    localparam int         HOLD_CYCLES = 400;
    localparam int         LIMIT_CYCLES = 400000;

    // Predicts the parse result of each string and checks the block's results.
    class token_scoreboard;
        phase_t      ph;
        logic        hex;
        logic [31:0] acc;
        logic        seen;
        int          pos;
        int          rest_at;
        result_t     expected_tokens[$];
        int          failures;

        function void clear();
            ph      = PH_LEAD;
            hex     = 1'b0;
            acc     = 32'd0;
            seen    = 1'b0;
            pos     = 0;
            rest_at = 0;
        endfunction

        function logic [4:0] digit_of(input logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return 5'(c - CH_ZERO);
            if (c >= CH_UP_A && c <= CH_UP_F)
                return 5'(c - CH_UP_A + 8'd10);
            if (c >= CH_LOW_A && c <= CH_LOW_F)
                return 5'(c - CH_LOW_A + 8'd10);
            return NOT_HEX;
        endfunction

        // A character inside the digits either extends the number or ends it.
        function void take_digit(input logic [7:0] c);
            logic [4:0] d;
            logic [4:0] base;
            d    = digit_of(c);
            base = hex ? HEX_BASE : DEC_BASE;
            if (d != NOT_HEX) begin
                if (d >= base)
                    ph = PH_FAIL;
                else begin
                    acc  = acc * 32'(base) + 32'(d);
                    seen = 1'b1;
                end
            end else if (!seen || c != CH_SPACE)
                ph = PH_FAIL;
            else
                ph = PH_TRAIL;
        endfunction

        // Advances the parse by one accepted character.
        function void note_char(input logic [7:0] c, input logic is_last);
            result_t res;
            case (ph)
                PH_LEAD:
                begin
                    if (c == CH_DOLLAR) begin
                        hex = 1'b1;
                        ph  = PH_DIGITS;
                    end else if (c == CH_ZERO)
                        ph = PH_ZERO;
                    else if (c != CH_SPACE) begin
                        ph = PH_DIGITS;
                        take_digit(c);
                    end
                end
                PH_ZERO:
                begin
                    if (c == CH_LOW_X || c == CH_UP_X) begin
                        hex = 1'b1;
                        ph  = PH_DIGITS;
                    end else begin
                        acc  = 32'd0;
                        seen = 1'b1;
                        ph   = PH_DIGITS;
                        take_digit(c);
                    end
                end
                PH_DIGITS:
                    take_digit(c);
                PH_TRAIL:
                begin
                    if (c != CH_SPACE) begin
                        rest_at = pos;
                        ph      = PH_REST;
                    end
                end
                PH_REST:
                    ;
                default:
                    ph = PH_FAIL;
            endcase
            if (pos < MAX_LEN)
                pos++;
            if (!is_last)
                return;

            // The final character closes the string and yields one result.
            res = '0;
            case (ph)
                PH_ZERO:
                begin
                    res.ok          = 1'b1;
                    res.rest_offset = 8'(pos);
                end
                PH_DIGITS:
                begin
                    if (seen) begin
                        res.ok          = 1'b1;
                        res.value       = acc;
                        res.rest_offset = 8'(pos);
                    end
                end
                PH_TRAIL:
                begin
                    res.ok          = 1'b1;
                    res.value       = acc;
                    res.rest_offset = 8'(pos);
                end
                PH_REST:
                begin
                    res.ok          = 1'b1;
                    res.value       = acc;
                    res.rest_offset = 8'(rest_at);
                end
                default:
                    ;
            endcase
            expected_tokens.push_back(res);
            clear();
        endfunction

        // Compares one accepted result with the oldest expected one.
        function void check_result(input logic o, input logic [31:0] v,
                                   input logic [7:0] off);
            result_t want;
            if (expected_tokens.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result ok=%0b value=%h rest_offset=%0d",
                             $time, o, v, off);
                return;
            end
            want = expected_tokens.pop_front();
            if (want.ok !== o || want.value !== v || want.rest_offset !== off) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch: expected ok=%0b value=%h rest_offset=%0d, got ok=%0b value=%h rest_offset=%0d",
                             $time, want.ok, want.value, want.rest_offset, o, v, off);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic        ok;
    logic [31:0] value;
    logic [7:0]  rest_offset;

    bit          rx_hold = 1'b0;
    bit          rx_eager = 1'b0;
    int          items_sent = 0;

    token_scoreboard tokens = new();

    unsigned_number_token_parser_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .value       (value),
        .rest_offset (rest_offset)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic byte_q_t text_chars(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Builds one random string: mostly well-formed tokens with random content,
    // the rest raw noise or tokens with one character spoilt.
    function automatic byte_q_t make_token();
        byte_q_t q;
        string   hex_digits;
        int      prefix;
        int      ndig;
        hex_digits = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 6))
                q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        repeat ($urandom_range(0, 3) == 3 ? $urandom_range(1, 3) : 0)
            q.push_back(CH_SPACE);
        prefix = $urandom_range(0, 4);
        case (prefix)
            1: q.push_back(CH_DOLLAR);
            2: q = {q, CH_ZERO, CH_LOW_X};
            3: q = {q, CH_ZERO, CH_UP_X};
            4: q.push_back(CH_ZERO);
            default: ;
        endcase
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
        repeat (ndig) begin
            if (prefix >= 1 && prefix <= 3)
                q.push_back(hex_digits[$urandom_range(0, 21)]);
            else
                q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        repeat ($urandom_range(0, 2))
            q.push_back(CH_SPACE);
        if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 3))
                q.push_back(8'($urandom_range(0, 255)));
        if (q.size() == 0)
            q.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
        if ($urandom_range(0, 99) < 15)
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        return q;
    endfunction

    // Sender idles with valid low for the given gap.
    task automatic idle_sender(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Offers the characters of one string in order, the final one marked.
    task automatic send_string(input byte_q_t chars, input bit eager);
        logic fin;
        foreach (chars[i]) begin
            if (!eager)
                idle_sender(pick_gap());
            fin = (i == chars.size() - 1);
            in_valid <= 1'b1;
            ch       <= chars[i];
            last     <= fin;
            do
                @(posedge clk);
            while (!in_ready);
            tokens.note_char(chars[i], fin);
            items_sent++;
            @(negedge clk);
        end
    endtask

    // Result receiver: random stall windows, a long hold on request.
    initial
    begin : receiver
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (rx_hold) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold = 1'b0;
            end else begin
                stall = rx_eager ? 0 : pick_gap();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    // Results are checked at the rising edge on which they are accepted.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            tokens.check_result(ok, value, rest_offset);
    end

    // Stimulus.
    initial
    begin : stimulus
        byte_q_t token;
        int      k;
        tokens.clear();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        ch       = 8'd0;
        last     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corner cases: lone zero, both hex prefixes, a letter in
        // decimal, leading and trailing spaces with text after, all spaces,
        // a bad terminator, a prefix with no digits, and the byte extremes.
        send_string(text_chars("0"), 1'b0);
        send_string(text_chars("$fF"), 1'b0);
        send_string(text_chars("0XA"), 1'b0);
        send_string(text_chars("9a"), 1'b0);
        send_string(text_chars(" 7 z"), 1'b0);
        send_string(text_chars("  "), 1'b0);
        send_string(text_chars("5,"), 1'b0);
        send_string(text_chars("0x"), 1'b0);
        token = {8'hFF};
        send_string(token, 1'b0);
        token = {8'h34, 8'h00};
        send_string(token, 1'b0);

        // Random strings, with the pressure phases placed early on.
        k = 0;
        while (items_sent < 550 || k < 50) begin
            if (k == 5) begin
                // Results held back while characters keep coming.
                rx_hold = 1'b1;
                while (rx_hold)
                    send_string(make_token(), 1'b1);
            end else if (k == 15) begin
                // A string longer than the position counter can count.
                token = text_chars("  123");
                repeat (252) token.push_back(CH_SPACE);
                send_string(token, 1'b0);
            end else if (k == 20) begin
                // Sender waits until every outstanding result has come.
                in_valid <= 1'b0;
                @(negedge clk);
                while (tokens.expected_tokens.size() != 0)
                    @(negedge clk);
                send_string(make_token(), 1'b0);
            end else begin
                rx_eager = (k >= 25 && k < 35);
                send_string(make_token(), rx_eager);
            end
            k++;
        end
        rx_eager = 1'b0;

        // Drain the outstanding results, then idle before the verdict.
        in_valid <= 1'b0;
        while (tokens.expected_tokens.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (tokens.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
